// File: sv/assert_macros.svh
// Assertion helpers for the checker in dtsi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dtsi_pkg.sv
package dtsi_pkg;

  localparam int CharW   = 8;
  localparam int MagW    = 33;
  localparam int GrowW   = 37;  // magnitude * 10 + 9 fits here
  localparam int PhaseW  = 3;
  localparam int KindW   = 2;
  localparam int StatusW = 2;
  localparam int DecBase = 10;

  // Parse phases
  localparam logic [PhaseW-1:0] PH_LEAD      = 3'd0;
  localparam logic [PhaseW-1:0] PH_SIGN      = 3'd1;
  localparam logic [PhaseW-1:0] PH_DIGITS    = 3'd2;
  localparam logic [PhaseW-1:0] PH_TRAIL_WS  = 3'd3;
  localparam logic [PhaseW-1:0] PH_TRAIL_BAD = 3'd4;
  localparam logic [PhaseW-1:0] PH_BAD       = 3'd5;

  // Number kinds
  localparam logic [KindW-1:0] KIND_S8  = 2'd0;
  localparam logic [KindW-1:0] KIND_U8  = 2'd1;
  localparam logic [KindW-1:0] KIND_U16 = 2'd2;
  localparam logic [KindW-1:0] KIND_U32 = 2'd3;

  // Result status
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_SYNTAX = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE  = 2'd2;

  // Characters
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;

  // Saturation point and kind limits
  localparam logic [MagW-1:0] MAG_CAP     = 33'h1_0000_0000;
  localparam logic [MagW-1:0] LIM_S8_POS  = 33'd127;
  localparam logic [MagW-1:0] LIM_S8_NEG  = 33'd128;
  localparam logic [MagW-1:0] LIM_U8      = 33'h0_0000_00FF;
  localparam logic [MagW-1:0] LIM_U16     = 33'h0_0000_FFFF;
  localparam logic [MagW-1:0] LIM_U32     = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              is_negative;
    logic [MagW-1:0]   magnitude;
    logic              saw_minus;
    logic              string_empty;
  } parse_state_t;

  typedef struct packed {
    logic signed [MagW-1:0] parsed_value;
    logic [StatusW-1:0]     parse_status;
  } result_t;

  localparam parse_state_t STATE_IDLE = '{
    phase:        PH_LEAD,
    is_negative:  1'b0,
    magnitude:    '0,
    saw_minus:    1'b0,
    string_empty: 1'b1
  };

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: sv/dtsi_char_if.sv
interface dtsi_char_if import dtsi_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink (input valid, input text_char, output ready);
endinterface

// File: sv/dtsi_result_if.sv
interface dtsi_result_if import dtsi_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [MagW-1:0] parsed_value;
  logic [StatusW-1:0]     parse_status;

  modport source (output valid, output parsed_value, output parse_status, input ready);
  modport sink (input valid, input parsed_value, input parse_status, output ready);
endinterface

// File: sv/dtsi_parser.sv
module dtsi_parser import dtsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [CharW-1:0] text_char,
  output parse_state_t     state
);

  parse_state_t     state_next;
  logic             is_dig;
  logic             ch_ws;
  logic [GrowW-1:0] grown;
  logic [MagW-1:0]  mag_step;

  // Decimal accumulate with saturation at 2^32
  always_comb begin
    is_dig   = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    ch_ws    = is_ws(text_char);
    grown    = GrowW'(state.magnitude) * GrowW'(DecBase) + GrowW'(text_char[3:0]);
    mag_step = (grown > GrowW'(MAG_CAP)) ? MAG_CAP : grown[MagW-1:0];
  end

  // Phase and flag update for one non-terminating character
  always_comb begin
    state_next              = state;
    state_next.string_empty = 1'b0;
    if (text_char == CH_MINUS) begin
      state_next.saw_minus = 1'b1;
    end
    case (state.phase)
      PH_LEAD: begin
        if (ch_ws) begin
          state_next.phase = PH_LEAD;
        end else if ((text_char == CH_PLUS) || (text_char == CH_MINUS)) begin
          state_next.is_negative = (text_char == CH_MINUS);
          state_next.phase       = PH_SIGN;
        end else if (is_dig) begin
          state_next.magnitude = mag_step;
          state_next.phase     = PH_DIGITS;
        end else begin
          state_next.phase = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (is_dig) begin
          state_next.magnitude = mag_step;
          state_next.phase     = PH_DIGITS;
        end else begin
          state_next.phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_dig) begin
          state_next.magnitude = mag_step;
        end else begin
          state_next.phase = ch_ws ? PH_TRAIL_WS : PH_TRAIL_BAD;
        end
      end
      PH_TRAIL_WS: begin
        if (!ch_ws) begin
          state_next.phase = PH_TRAIL_BAD;
        end
      end
      PH_TRAIL_BAD: begin
        state_next.phase = PH_TRAIL_BAD;
      end
      default: begin
        state_next.phase = PH_BAD;
      end
    endcase
  end

  // State register; the terminator returns it to idle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
    end else if (take) begin
      if (text_char == CH_NUL) begin
        state <= STATE_IDLE;
      end else begin
        state <= state_next;
      end
    end
  end

endmodule

// File: sv/dtsi_finish.sv
module dtsi_finish import dtsi_pkg::*; (
  input  parse_state_t     state,
  input  logic [KindW-1:0] number_kind,
  output result_t          result
);

  logic            unsig;
  logic            has_digits;
  logic            in_range;
  logic [MagW-1:0] limit;

  // Upper bound of the magnitude for the configured kind
  always_comb begin
    case (number_kind)
      KIND_S8:  limit = state.is_negative ? LIM_S8_NEG : LIM_S8_POS;
      KIND_U8:  limit = LIM_U8;
      KIND_U16: limit = LIM_U16;
      KIND_U32: limit = LIM_U32;
      default:  limit = LIM_U32;
    endcase
    unsig      = (number_kind != KIND_S8);
    in_range   = (state.magnitude <= limit);
    has_digits = (state.phase == PH_DIGITS) || (state.phase == PH_TRAIL_WS) ||
                 (state.phase == PH_TRAIL_BAD);
  end

  // Status priority: empty, stray minus, range, trailing garbage
  always_comb begin
    result.parsed_value = '0;
    result.parse_status = ST_SYNTAX;
    if (state.string_empty) begin
      result.parse_status = ST_SYNTAX;
    end else if (unsig && state.saw_minus) begin
      result.parse_status = ST_SYNTAX;
    end else if (has_digits) begin
      if (!in_range) begin
        result.parse_status = ST_RANGE;
      end else if (state.phase == PH_TRAIL_BAD) begin
        result.parse_status = ST_SYNTAX;
      end else begin
        result.parse_status = ST_OK;
        result.parsed_value = state.is_negative ? -$signed(state.magnitude)
                                                : $signed(state.magnitude);
      end
    end else if ((state.phase == PH_LEAD) && unsig) begin
      // whitespace only reads as zero in the unsigned kinds
      result.parse_status = ST_OK;
    end
  end

endmodule

// File: sv/dtsi_out_buf.sv
module dtsi_out_buf import dtsi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign has_room  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Control: skid only fills while the head is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

// File: sv/decimal_text_to_small_integer_top.sv
// Decimal text parser: takes one character per cycle and converts a
// zero-terminated decimal string the way strtol (signed 8-bit kind) or
// strtoul (unsigned 8/16/32-bit kinds) would, selected by the 2-bit
// number_kind register (cfg_we/cfg_data, write only while idle). Every
// character, the terminator included, is a single-cycle transaction;
// the parse state is one register updated by a multiply-by-ten-and-add
// per digit. On the accepted terminator the result is registered into
// a two-entry output buffer that keeps the input side moving
// while one result waits; input stalls only when both entries are full.
// Status is 0 ok, 1 invalid syntax, 2 out of range; the value is zero
// unless the status is ok.
module decimal_text_to_small_integer_top import dtsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  dtsi_char_if.sink        chars,
  dtsi_result_if.source    results,
  input  logic             cfg_we,
  input  logic [KindW-1:0] cfg_data
);

  logic [KindW-1:0] number_kind;
  parse_state_t     state;
  result_t          result;
  result_t          out_data;
  logic             take;
  logic             has_room;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_kind <= KIND_S8;
    end else if (cfg_we) begin
      number_kind <= cfg_data;
    end
  end

  assign chars.ready = has_room;
  assign take        = chars.valid && has_room;

  dtsi_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_char (chars.text_char),
    .state     (state)
  );

  dtsi_finish u_finish (
    .state       (state),
    .number_kind (number_kind),
    .result      (result)
  );

  dtsi_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && (chars.text_char == CH_NUL)),
    .push_data (result),
    .has_room  (has_room),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (out_data)
  );

  assign results.parsed_value = out_data.parsed_value;
  assign results.parse_status = out_data.parse_status;

endmodule

// File: sv/dtsi_checker.sv
`include "assert_macros.svh"

module dtsi_checker import dtsi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [CharW-1:0]       text_char,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [MagW-1:0] parsed_value,
  input logic [StatusW-1:0]     parse_status
);

  // Failed parses carry a zero value
  `ASSERT_IMPLIES(a_zero_on_error, clk, rst, out_valid && (parse_status != ST_OK), parsed_value == '0, "nonzero value with error status")

  // A new result only follows an accepted terminator
  `ASSERT_IMPLIES(a_result_from_nul, clk, rst, $rose(out_valid), $past(in_valid && in_ready && (text_char == CH_NUL)), "result without terminator")

  // With no result pending the input side is open
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled with empty output")

  // Reset empties the output
  `ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid, "result present after reset")

  // A stalled result holds
  `ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready, out_valid && $stable(parsed_value) && $stable(parse_status), "stalled result changed")

endmodule

bind decimal_text_to_small_integer_top dtsi_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (chars.valid),
  .in_ready     (chars.ready),
  .text_char    (chars.text_char),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .parsed_value (results.parsed_value),
  .parse_status (results.parse_status)
);
